>>> design/emw_pkg.sv
// Shared widths and types for the Euclidean minimum spanning tree weight block.
// No dependencies; imported by every module of the block except emw_fifo.
`default_nettype none
package emw_pkg;
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int LEN_W    = 2 * DIFF_W;
  localparam int ROOT_W   = DIFF_W;
  localparam int WEIGHT_W = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;
endpackage
`default_nettype wire

>>> design/euclidean_mst_weight.sv
// Euclidean MST weight: points load at one per cycle while in_stall is low; after the
// last point of a set with n stored points the result follows one distance scan over
// the n points, a pipeline drain and a bit-serial square root per tree edge. Sets of
// zero or one point skip the tree and answer with weight zero. Input stalls from the
// last point until the result is loaded into the output register.
// Reset (synchronous) clears control only; point and distance memories stay as is.
`default_nettype none
module euclidean_mst_weight #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [emw_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [emw_pkg::COORD_W-1:0]  point_y,
  input  wire logic                                last_point,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [emw_pkg::WEIGHT_W-1:0]             tree_weight,
  output logic                                     overflow
);
  import emw_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic          pt_we;
  logic [IW-1:0] pt_addr;
  point_t        pt_data;
  logic          job_push, job_pop, job_full, job_empty;
  logic [CW:0]   job_in, job_out;
  logic          set_done;

  // front: load points
  emw_front #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point),
    .pt_we      (pt_we),
    .pt_addr    (pt_addr),
    .pt_data    (pt_data),
    .job_push   (job_push),
    .job_data   (job_in),
    .job_full   (job_full),
    .set_done   (set_done)
  );

  // queue of closed sets
  emw_fifo #(.WIDTH(CW + 1)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .full      (job_full),
    .empty     (job_empty)
  );

  // back: build the tree and sum its edges
  emw_back #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .pt_we       (pt_we),
    .pt_addr     (pt_addr),
    .pt_data     (pt_data),
    .job_data    (job_out),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .set_done    (set_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tree_weight (tree_weight),
    .overflow    (overflow)
  );
endmodule
`default_nettype wire

>>> design/emw_fifo.sv
// Two-entry request queue between the loading front and the tree back end.
// Depends on nothing.
`default_nettype none
module emw_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rptr];

  // store incoming requests
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/emw_front.sv
// Load front: takes points, counts them, flags overflow and queues one set request.
// Depends on emw_pkg.
`default_nettype none
module emw_front #(
  parameter int MAX_POINTS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [emw_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [emw_pkg::COORD_W-1:0] point_y,
  input  wire logic                          last_point,
  output logic                               pt_we,
  output logic [IW-1:0]                      pt_addr,
  output emw_pkg::point_t                    pt_data,
  output logic                               job_push,
  output logic [CW:0]                        job_data,
  input  wire logic                          job_full,
  input  wire logic                          set_done
);
  import emw_pkg::*;

  logic [CW-1:0] count;
  logic          ovf_seen;
  logic          busy;
  logic          acc;
  logic          room;

  assign in_stall = busy | job_full;
  assign acc      = in_valid & ~in_stall;
  assign room     = (count < CW'(MAX_POINTS));

  // write the point while there is room
  assign pt_we     = acc & room;
  assign pt_addr   = count[IW-1:0];
  assign pt_data.x = point_x;
  assign pt_data.y = point_y;

  // close the set on its last point
  assign job_push = acc & last_point;
  assign job_data = {ovf_seen | ~room, room ? count + CW'(1) : count};

  // hold off new points until the back end has the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
      busy     <= 1'b0;
    end else begin
      if (acc) begin
        if (last_point) begin
          count    <= '0;
          ovf_seen <= 1'b0;
          busy     <= 1'b1;
        end else if (room) begin
          count <= count + CW'(1);
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if (set_done) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> design/emw_isqrt.sv
// Bit-serial floor square root, one root bit per cycle.
// Depends on emw_pkg.
`default_nettype none
module emw_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [emw_pkg::LEN_W-1:0]   value,
  output logic                             busy,
  output logic                             done,
  output logic [emw_pkg::ROOT_W-1:0]       root
);
  import emw_pkg::*;

  localparam int NW = $clog2(ROOT_W + 1);

  logic [LEN_W-1:0]  val;
  logic [ROOT_W:0]   rem;
  logic [NW-1:0]     cnt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              take;

  assign rem_sh = {rem, val[LEN_W-1:LEN_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = (rem_sh >= trial);

  // datapath: shift in two bits, try subtract
  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[LEN_W-3:0], 2'b00};
      rem  <= take ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
      root <= {root[ROOT_W-2:0], take};
    end
  end

  // control: count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/emw_back.sv
// Tree back end: per-set nearest-neighbor growth over the stored points with a
// distance table, square root of each chosen edge and the weight sum.
// Depends on emw_pkg and emw_isqrt.
`default_nettype none
module emw_back #(
  parameter int MAX_POINTS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pt_we,
  input  wire logic [IW-1:0]                 pt_addr,
  input  wire emw_pkg::point_t               pt_data,
  input  wire logic [CW:0]                   job_data,
  input  wire logic                          job_empty,
  output logic                               job_pop,
  output logic                               set_done,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [emw_pkg::WEIGHT_W-1:0]       tree_weight,
  output logic                               overflow
);
  import emw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // memories
  point_t           pmem [MAX_POINTS];
  logic [LEN_W:0]   dmem [MAX_POINTS];
  point_t           rd_pt;
  logic [LEN_W:0]   rd_d;

  logic [2:0]          state;
  logic [CW-1:0]       n;
  logic                ovf;
  logic [CW-1:0]       scan_j;
  logic [CW-1:0]       round;
  logic [IW-1:0]       cur;
  point_t              cur_pt;
  logic [LEN_W-1:0]    best;
  logic [IW-1:0]       best_j;
  point_t              best_pt;
  logic                best_ok;
  logic [WEIGHT_W-1:0] total;

  // pipeline stages
  logic                v1, v2, v3, v4, v5;
  logic [IW-1:0]       j1, j2, j3, j4, j5;
  logic [DIFF_W-1:0]   dx2, dy2;
  logic [LEN_W-1:0]    sqx3, sqy3, len4, dold2, dold3, dold4, d5;
  logic                vis2, vis3, vis4;
  logic                self2, self3, self4;
  point_t              pt2, pt3, pt4, pt5;
  logic                cand5;

  logic signed [DIFF_W-1:0] ddx, ddy;
  logic [DIFF_W-1:0]   adx, ady;
  logic [LEN_W-1:0]    newd;
  logic                first;
  logic                pipe_empty;

  logic                sq_start, sq_busy, sq_done;
  logic [ROOT_W-1:0]   sq_root;

  assign first      = (round == '0);
  assign pipe_empty = !(v1 | v2 | v3 | v4 | v5);
  assign job_pop    = (state == ST_IDLE) && !job_empty && !out_valid;
  assign sq_start   = (state == ST_DRAIN) && pipe_empty;

  // point memory: front writes, scan reads
  always_ff @(posedge clk) begin
    if (pt_we) pmem[pt_addr] <= pt_data;
    rd_pt <= pmem[scan_j[IW-1:0]];
  end

  // distance memory: visited flag over best squared distance so far
  always_ff @(posedge clk) begin
    if (v4) dmem[j4] <= {vis4 | self4, newd};
    rd_d <= dmem[scan_j[IW-1:0]];
  end

  // stage 1: coordinate differences against the current tree point
  assign ddx = DIFF_W'(rd_pt.x) - DIFF_W'(cur_pt.x);
  assign ddy = DIFF_W'(rd_pt.y) - DIFF_W'(cur_pt.y);
  assign adx = ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
  assign ady = ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);

  // stage 4: relax the distance
  assign newd = (first || len4 < dold4) ? len4 : dold4;

  // advance the scan pipeline payload
  always_ff @(posedge clk) begin
    j1    <= scan_j[IW-1:0];
    j2    <= j1;
    dx2   <= adx;
    dy2   <= ady;
    pt2   <= rd_pt;
    dold2 <= rd_d[LEN_W-1:0];
    vis2  <= first ? 1'b0 : rd_d[LEN_W];
    self2 <= (j1 == cur);
    j3    <= j2;
    sqx3  <= dx2 * dx2;
    sqy3  <= dy2 * dy2;
    pt3   <= pt2;
    dold3 <= dold2;
    vis3  <= vis2;
    self3 <= self2;
    j4    <= j3;
    len4  <= sqx3 + sqy3;
    pt4   <= pt3;
    dold4 <= dold3;
    vis4  <= vis3;
    self4 <= self3;
    j5    <= j4;
    d5    <= newd;
    pt5   <= pt4;
    cand5 <= !vis4 && !self4;
  end

  // advance pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= (state == ST_SCAN);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  emw_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (best),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      set_done  <= 1'b0;
      best_ok   <= 1'b0;
    end else begin
      set_done <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      // stage 5: keep the nearest point outside the tree
      if (v5 && cand5 && (!best_ok || d5 < best)) begin
        best    <= d5;
        best_j  <= j5;
        best_pt <= pt5;
        best_ok <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_pop) begin
            n      <= job_data[CW-1:0];
            ovf    <= job_data[CW];
            total  <= '0;
            scan_j <= '0;
            round  <= '0;
            cur    <= '0;
            state  <= (job_data[CW-1:0] < CW'(2)) ? ST_FIN : ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_PICK;
        ST_PICK: begin
          cur_pt  <= rd_pt;
          best_ok <= 1'b0;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_j == n - CW'(1)) begin
            state <= ST_DRAIN;
          end else begin
            scan_j <= scan_j + CW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            cur    <= best_j;
            cur_pt <= best_pt;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            total <= total + WEIGHT_W'(sq_root);
            if (round == n - CW'(2)) begin
              state <= ST_FIN;
            end else begin
              round   <= round + CW'(1);
              scan_j  <= '0;
              best_ok <= 1'b0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_FIN: begin
          out_valid   <= 1'b1;
          tree_weight <= total;
          overflow    <= ovf;
          set_done    <= 1'b1;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst) sq_start |-> !sq_busy)
    else $error("square root started while busy");
  a_scan_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (n >= CW'(2)))
    else $error("scan on a set below two points");
  a_done_out: assert property (@(posedge clk) disable iff (rst) set_done |-> out_valid)
    else $error("set released without a result");
`endif
endmodule
`default_nettype wire
